// ===== sv/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// mar_pkg
// Shared types and constants of the matrix argmax reduction block.
// ----------------------------------------------------------------------------
package mar_pkg;

   localparam int VALUE_W     = 32;   // signed Q16.16 element
   localparam int INDEX_W     = 20;   // flattened result index
   localparam int CFG_W       = 11;   // widest configuration register
   localparam int CSR_IDX_W   = 2;
   localparam int MODE_W      = 2;

   localparam int MAX_ROWS_DEF  = 1024;
   localparam int MAX_COLS_DEF  = 1024;
   localparam int RSP_DEPTH_DEF = 4;

   // register indices
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd2;

   // reduction modes (the unused code behaves as the whole-tensor mode)
   localparam logic [MODE_W-1:0] MODE_TENSOR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ROW    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COL    = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic               final_res;
   } rsp_type;

endpackage

// ===== sv/mar_ram.sv =====
// ----------------------------------------------------------------------------
// mar_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mar_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// mar_rsp_fifo
// Small flop-based result queue that decouples the update stage from the
// result channel.
// ----------------------------------------------------------------------------
module mar_rsp_fifo
   import mar_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEF,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_type       push_data,
   input  logic          pop,
   output logic          not_empty,
   output rsp_type       head,
   output logic [PW:0]   count
);

   rsp_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      if (p == PW'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("result queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == (PW+1)'(DEPTH)))
      else $error("result queue pushed while full");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("result queue count did not advance");
`endif

endmodule

// ===== sv/matrix_argmax_reduce_top.sv =====
// An element is registered into the update stage, its result into the result queue.
// Throughput: one element per cycle; the column store is read on accept and
// written back the next cycle, a bypass register covering back-to-back hits.
// Results queue in a four-entry buffer; input stalls only when it may fill.
// Reset (synchronous) clears position, running best, mode and sizes; the
// column store is not cleared, row 0 writes every entry before it is read.
// ----------------------------------------------------------------------------
// matrix_argmax_reduce_top
// Streaming argmax over a row-major matrix: whole tensor, per row or per
// column, first occurrence wins ties.
// ----------------------------------------------------------------------------
module matrix_argmax_reduce_top
   import mar_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [INDEX_W-1:0]        rsp_best_index,
   output logic                      rsp_final_res,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int FLAT_W = ROW_W + COL_W;
   localparam int RAM_W  = VALUE_W + FLAT_W;
   localparam int RSP_PW = (RSP_DEPTH_DEF > 1) ? $clog2(RSP_DEPTH_DEF) : 1;

   // ---------------------------------------------------------------- config
   logic [MODE_W-1:0] mode_ff;
   logic [ROW_W-1:0]  rows_last_ff;
   logic [COL_W-1:0]  cols_last_ff;
   logic              csr_hit;

   // size register to index of its last row/column, zero counts as one
   function automatic logic [31:0] dim_last(input logic [CFG_W-1:0] v, input int limit);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         return 32'd0;
      end
      if (w > 32'(limit)) begin
         return 32'(limit - 1);
      end
      return w - 32'd1;
   endfunction

   assign csr_hit = csr_wr_en &&
                    (csr_index == CSR_MODE || csr_index == CSR_ROWS || csr_index == CSR_COLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TENSOR;
         rows_last_ff <= '0;
         cols_last_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE: begin
               mode_ff <= csr_wdata[MODE_W-1:0];
            end
            CSR_ROWS: begin
               rows_last_ff <= ROW_W'(dim_last(csr_wdata, MAX_ROWS));
            end
            CSR_COLS: begin
               cols_last_ff <= COL_W'(dim_last(csr_wdata, MAX_COLS));
            end
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------- position stage
   logic              req_accept;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [COL_W-1:0]  col_pos_ff, col_pos_in;
   logic [FLAT_W-1:0] flat_ff, flat_in;
   logic              at_last_row, at_last_col;

   assign req_accept  = req_valid && !req_stall;
   assign at_last_row = (row_pos_ff == rows_last_ff);
   assign at_last_col = (col_pos_ff == cols_last_ff);

   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      flat_in    = flat_ff;
      if (csr_hit) begin
         row_pos_in = '0;
         col_pos_in = '0;
         flat_in    = '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_pos_in = '0;
            row_pos_in = at_last_row ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
         flat_in = (at_last_row && at_last_col) ? '0 : flat_ff + 1'b1;
      end
   end

   // --------------------------------------------------------- update stage
   logic                      s2_valid_ff;
   logic signed [VALUE_W-1:0] s2_value_ff;
   logic [FLAT_W-1:0]         s2_idx_ff;
   logic [COL_W-1:0]          s2_col_ff;
   logic                      s2_first_row_ff, s2_first_col_ff;
   logic                      s2_last_row_ff, s2_last_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         flat_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         row_pos_ff  <= row_pos_in;
         col_pos_ff  <= col_pos_in;
         flat_ff     <= flat_in;
         s2_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s2_value_ff     <= req_value;
         s2_idx_ff       <= flat_ff;
         s2_col_ff       <= col_pos_ff;
         s2_first_row_ff <= (row_pos_ff == '0);
         s2_first_col_ff <= (col_pos_ff == '0);
         s2_last_row_ff  <= at_last_row;
         s2_last_col_ff  <= at_last_col;
      end
   end

   // column store: {best value, best index} per column
   logic [RAM_W-1:0] ram_rd_data;
   logic [RAM_W-1:0] ram_wr_data;
   logic             ram_wr_en;

   mar_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_COLS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s2_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // bypass of the write that landed on the same edge as this beat's read
   logic                      wb_valid_ff;
   logic [COL_W-1:0]          wb_col_ff;
   logic [RAM_W-1:0]          wb_data_ff;
   logic [RAM_W-1:0]          col_entry;
   logic signed [VALUE_W-1:0] col_best_value;
   logic [FLAT_W-1:0]         col_best_idx;

   logic signed [VALUE_W-1:0] run_value_ff, run_value_in;
   logic [FLAT_W-1:0]         run_idx_ff, run_idx_in;
   logic                      take;
   logic [FLAT_W-1:0]         res_idx;
   logic                      res_valid;
   logic                      res_final;
   logic [FLAT_W+INDEX_W-1:0] res_idx_ext;
   rsp_type                   res_beat;

   assign col_entry      = (wb_valid_ff && wb_col_ff == s2_col_ff) ? wb_data_ff : ram_rd_data;
   assign col_best_value = col_entry[RAM_W-1:FLAT_W];
   assign col_best_idx   = col_entry[FLAT_W-1:0];

   always_comb begin
      run_value_in = run_value_ff;
      run_idx_in   = run_idx_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = col_entry;
      take         = 1'b0;
      res_idx      = run_idx_ff;
      res_valid    = 1'b0;
      res_final    = 1'b0;
      case (mode_ff)
         MODE_ROW: begin
            take = s2_first_col_ff || (s2_value_ff > run_value_ff);
            if (take) begin
               run_value_in = s2_value_ff;
               run_idx_in   = s2_idx_ff;
            end
            res_idx   = run_idx_in;
            res_valid = s2_valid_ff && s2_last_col_ff;
            res_final = s2_last_row_ff;
         end
         MODE_COL: begin
            take      = s2_first_row_ff || (s2_value_ff > col_best_value);
            ram_wr_en = s2_valid_ff;
            if (take) begin
               ram_wr_data = {s2_value_ff, s2_idx_ff};
               res_idx     = s2_idx_ff;
            end else begin
               res_idx = col_best_idx;
            end
            res_valid = s2_valid_ff && s2_last_row_ff;
            res_final = s2_last_col_ff;
         end
         default: begin
            take = (s2_first_row_ff && s2_first_col_ff) || (s2_value_ff > run_value_ff);
            if (take) begin
               run_value_in = s2_value_ff;
               run_idx_in   = s2_idx_ff;
            end
            res_idx   = run_idx_in;
            res_valid = s2_valid_ff && s2_last_row_ff && s2_last_col_ff;
            res_final = 1'b1;
         end
      endcase
      res_idx_ext         = {INDEX_W'(0), res_idx};
      res_beat.best_index = res_idx_ext[INDEX_W-1:0];
      res_beat.final_res  = res_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_idx_ff   <= '0;
         wb_valid_ff  <= 1'b0;
      end else begin
         if (s2_valid_ff) begin
            run_value_ff <= run_value_in;
            run_idx_ff   <= run_idx_in;
         end
         wb_valid_ff <= ram_wr_en;
      end
      if (ram_wr_en) begin
         wb_col_ff  <= s2_col_ff;
         wb_data_ff <= ram_wr_data;
      end
   end

   // ---------------------------------------------------------- result queue
   logic            rsp_pop;
   logic [RSP_PW:0] rsp_count;
   rsp_type         rsp_head;

   assign rsp_pop = rsp_valid && !rsp_stall;

   mar_rsp_fifo #(
      .DEPTH (RSP_DEPTH_DEF)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_beat),
      .pop       (rsp_pop),
      .not_empty (rsp_valid),
      .head      (rsp_head),
      .count     (rsp_count)
   );

   // room for the beat in the update stage and the one being accepted
   assign req_stall      = ((RSP_PW+1)'(rsp_count) + (RSP_PW+1)'(s2_valid_ff))
                           >= (RSP_PW+1)'(RSP_DEPTH_DEF);
   assign rsp_best_index = rsp_head.best_index;
   assign rsp_final_res  = rsp_head.final_res;

`ifndef SYNTHESIS
   a_accept_enters_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s2_valid_ff)
      else $error("accepted beat missing from update stage");
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_pos_ff <= cols_last_ff)
      else $error("column position beyond last column");
   a_flat_at_origin: assert property (@(posedge clock) disable iff (reset)
      (row_pos_ff == '0 && col_pos_ff == '0) |-> (flat_ff == '0))
      else $error("flat index out of step with position");
   a_bypass_col_mode: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (mode_ff == MODE_COL))
      else $error("column store written outside column mode");
`endif

endmodule

// ===== tb/tb_matrix_argmax_reduce_top.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_argmax_reduce_top
// Self-checking bench for the streaming argmax block. A shadow copy of the
// position, running best and column store predicts every result beat. Runs
// directed cases first, then random tensor sizes and modes, with random gaps
// on both sides and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_matrix_argmax_reduce_top;
   import mar_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int RANDOM_ITEMS    = 640;
   localparam int SAT_PROBE       = 40;
   localparam int HOLD_CYCLES     = 48;
   localparam int SETTLE_CYCLES   = 4;
   localparam int FINAL_WAIT      = 8;
   localparam int WATCHDOG_CYCLES = 400000;
   localparam int GAP_PERCENT     = 22;

   // codes with no name in the package
   localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [INDEX_W-1:0]        rsp_best_index;
   logic                      rsp_final_res;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CFG_W-1:0]          csr_wdata;

   // shadow of the block
   logic [MODE_W-1:0]         shadow_mode;
   logic [CFG_W-1:0]          shadow_rows;
   logic [CFG_W-1:0]          shadow_cols;
   int unsigned               pos_row;
   int unsigned               pos_col;
   logic signed [VALUE_W-1:0] best_value;
   logic [INDEX_W-1:0]        best_index;
   logic signed [VALUE_W-1:0] col_best_value [MAX_COLS_DEF];
   logic [INDEX_W-1:0]        col_best_index [MAX_COLS_DEF];

   rsp_type                   pending_argmax [$];
   rsp_type                   arriving;

   bit                        gaps_on;
   bit                        hold_wanted;
   int                        hold_left;
   int                        mismatches;
   int                        items_sent;
   int                        results_checked;
   int                        input_stall_cycles;

   matrix_argmax_reduce_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_index (rsp_best_index),
      .rsp_final_res  (rsp_final_res),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * WATCHDOG_CYCLES);
      $display("timeout with %0d results outstanding", pending_argmax.size());
      $display("matrix_argmax_reduce_top test failed");
      $finish;
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                             input int unsigned limit);
      if (raw == '0)
         return 1;
      if (raw > limit)
         return limit;
      return 32'(raw);
   endfunction

   // Shadow step: returns nothing, queues the result beat the element causes.
   task automatic predict_argmax(input logic signed [VALUE_W-1:0] v);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      int unsigned flat;
      logic        last_row;
      logic        last_col;
      logic        emit;
      rsp_type     due;
      rows = clamp_dim(shadow_rows, MAX_ROWS_DEF);
      cols = clamp_dim(shadow_cols, MAX_COLS_DEF);
      r = pos_row;
      c = pos_col;
      if (r >= rows || c >= cols) begin
         r = 0;
         c = 0;
      end
      flat = r * cols + c;
      last_row = (r == rows - 1);
      last_col = (c == cols - 1);
      emit = 1'b0;
      due = '0;
      case (shadow_mode)
         MODE_ROW: begin
            if (c == 0 || v > best_value) begin
               best_value = v;
               best_index = flat[INDEX_W-1:0];
            end
            if (last_col) begin
               emit = 1'b1;
               due.best_index = best_index;
               due.final_res = last_row;
            end
         end
         MODE_COL: begin
            if (r == 0 || v > col_best_value[c]) begin
               col_best_value[c] = v;
               col_best_index[c] = flat[INDEX_W-1:0];
            end
            if (last_row) begin
               emit = 1'b1;
               due.best_index = col_best_index[c];
               due.final_res = last_col;
            end
         end
         default: begin
            // spare mode code falls in here with the whole-tensor mode
            if ((r == 0 && c == 0) || v > best_value) begin
               best_value = v;
               best_index = flat[INDEX_W-1:0];
            end
            if (last_row && last_col) begin
               emit = 1'b1;
               due.best_index = best_index;
               due.final_res = 1'b1;
            end
         end
      endcase
      if (emit)
         pending_argmax.push_back(due);
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows)
            r = 0;
      end
      pos_row = r;
      pos_col = c;
   endtask

   // Tasks below are entered at a falling edge and return at one with no
   // drive made there yet.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CFG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (index)
         CSR_MODE: shadow_mode = data[MODE_W-1:0];
         CSR_ROWS: shadow_rows = data;
         CSR_COLS: shadow_cols = data;
         default: ;
      endcase
      // any write to a real register restarts the tensor
      if (index != CSR_SPARE) begin
         pos_row = 0;
         pos_col = 0;
      end
   endtask

   task automatic set_shape(input logic [MODE_W-1:0] mode, input int rows, input int cols);
      write_reg(CSR_MODE, CFG_W'(mode));
      write_reg(CSR_ROWS, CFG_W'(rows));
      write_reg(CSR_COLS, CFG_W'(cols));
   endtask

   task automatic send_value(input logic signed [VALUE_W-1:0] v);
      while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      predict_argmax(v);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_argmax.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      int near_zero;
      near_zero = $urandom_range(6);
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return near_zero - 3;   // narrow spread, plenty of ties
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(9))
         0:       return 0;
         7, 8:    return $urandom_range(5, 12);
         9:       return $urandom_range(13, 20);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result checker and receiver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_argmax.size() == 0) begin
            $error("result beat with nothing expected: best_index %0d final_res %0b",
                   rsp_best_index, rsp_final_res);
            mismatches++;
         end else begin
            arriving = pending_argmax.pop_front();
            results_checked++;
            if (rsp_best_index !== arriving.best_index) begin
               $error("best_index: expected %0d, got %0d",
                      arriving.best_index, rsp_best_index);
               mismatches++;
            end
            if (rsp_final_res !== arriving.final_res) begin
               $error("final_res: expected %0b, got %0b", arriving.final_res, rsp_final_res);
               mismatches++;
            end
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // 1x1 whole tensor out of reset: every element is its own result
   task automatic test_reset_defaults();
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      wait_idle();
   endtask

   // spare mode code, the most negative value and a tie that the first occurrence must win
   task automatic test_tensor_ties();
      set_shape(MODE_SPARE, 2, 2);
      send_value(-5);
      send_value(7);
      send_value(7);
      send_value(32'sh8000_0000);
      wait_idle();
   endtask

   task automatic test_row_argmax();
      set_shape(MODE_ROW, 2, 3);
      send_value(3);
      send_value(3);
      send_value(1);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh7FFF_FFFF);
      wait_idle();
   endtask

   task automatic test_column_argmax();
      set_shape(MODE_COL, 3, 2);
      send_value(1);
      send_value(-1);
      send_value(1);
      send_value(5);
      send_value(2);
      send_value(32'sh8000_0000);
      wait_idle();
   endtask

   // a write to the spare index leaves the tensor alone, a real write restarts it
   task automatic test_restart_on_write();
      set_shape(MODE_TENSOR, 1, 2);
      send_value(5);
      wait_idle();
      write_reg(CSR_SPARE, '1);
      send_value(9);
      send_value(-1);
      wait_idle();
      write_reg(CSR_COLS, CFG_W'(2));
      send_value(-8);
      send_value(-8);
      wait_idle();
   endtask

   // sizes beyond the maximum saturate; the opening stretch of one tensor
   // in each direction, every element yielding a beat
   task automatic test_size_saturation();
      set_shape(MODE_COL, 1, 2047);
      repeat (SAT_PROBE) send_value(random_value());
      wait_idle();
      set_shape(MODE_ROW, 1025, 0);
      repeat (SAT_PROBE) send_value(random_value());
      wait_idle();
   endtask

   // receiver holds off while every element yields a beat, so the input backs up
   task automatic test_output_backpressure();
      set_shape(MODE_ROW, 3, 1);
      gaps_on = 1'b0;
      hold_wanted = 1'b1;
      repeat (32) send_value(random_value());
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_phases();
      int sent;
      int rows;
      int cols;
      int count;
      int first;
      logic [MODE_W-1:0] mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // one long stretch without gaps on either side
         gaps_on = !(sent >= 250 && sent < 420);
         mode = MODE_W'($urandom_range(3));
         rows = pick_dim();
         cols = pick_dim();
         first = $urandom_range(2);
         for (int i = 0; i < 3; i++) begin
            case ((first + i) % 3)
               0:       write_reg(CSR_MODE, {9'($urandom_range(511)), mode});
               1:       write_reg(CSR_ROWS, CFG_W'(rows));
               default: write_reg(CSR_COLS, CFG_W'(cols));
            endcase
         end
         if ($urandom_range(7) == 0)
            write_reg(CSR_SPARE, CFG_W'($urandom));
         count = clamp_dim(CFG_W'(rows), MAX_ROWS_DEF) * clamp_dim(CFG_W'(cols), MAX_COLS_DEF);
         if (count <= 64)
            count = count * $urandom_range(1, 3);
         // now and then stop part-way through a tensor
         if ($urandom_range(3) == 0)
            count = count + $urandom_range(1, 8);
         repeat (count) send_value(random_value());
         sent += count;
         wait_idle();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b1;
      hold_wanted = 1'b0;
      mismatches = 0;
      items_sent = 0;
      results_checked = 0;
      input_stall_cycles = 0;
      shadow_mode = MODE_TENSOR;
      shadow_rows = 1;
      shadow_cols = 1;
      pos_row = 0;
      pos_col = 0;
      best_value = '0;
      best_index = '0;
      for (int i = 0; i < MAX_COLS_DEF; i++) begin
         col_best_value[i] = '0;
         col_best_index[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_tensor_ties();
      test_row_argmax();
      test_column_argmax();
      test_restart_on_write();
      test_size_saturation();
      test_output_backpressure();
      test_random_phases();

      req_valid <= 1'b0;
      while (pending_argmax.size() != 0)
         @(negedge clock);
      repeat (FINAL_WAIT) @(negedge clock);

      $display("%0d elements sent, %0d argmax beats checked, input held back on %0d cycles",
               items_sent, results_checked, input_stall_cycles);
      $display("covered all mode codes, empty to saturated sizes, restarts and output hold-off");
      if (mismatches == 0 && pending_argmax.size() == 0)
         $display("matrix_argmax_reduce_top test passed");
      else
         $display("matrix_argmax_reduce_top test failed");
      $finish;
   end

endmodule

// ===== matrix_argmax_reduce_top.f =====
sv/mar_pkg.sv
sv/mar_ram.sv
sv/mar_rsp_fifo.sv
sv/matrix_argmax_reduce_top.sv
tb/tb_matrix_argmax_reduce_top.sv
